// ----- design/fourier_surface_position_unit_defines.svh -----
// assertion macros for the surface position unit
`ifndef FOURIER_SURFACE_POSITION_UNIT_DEFINES_SVH
`define FOURIER_SURFACE_POSITION_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSP_ASSERT(lbl, prop, msg)
`define FSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- design/fsp_pkg.sv -----
package fsp_pkg;

  localparam int FSP_MAX_SURFACES = 64;
  localparam int FSP_MAX_MODES    = 512;
  localparam int FSP_ANGLE_BITS   = 16;
  localparam int FSP_COEF_BITS    = 32;

  localparam int SURF_W     = 6;
  localparam int MODE_W     = 9;
  localparam int COEF_W     = 32;
  localparam int ANGLE_W    = 16;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_NTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MPOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NFP  = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // cordic: q4.30 values, angles in 2^-32 turn
  localparam int TRIG_W       = 34;
  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W       = 5;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/fsp_ifs.sv -----
interface fsp_in_if;
  import fsp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [SURF_W-1:0]         surface;
  logic [MODE_W-1:0]         mode;
  logic signed [COEF_W-1:0]  r_coef;
  logic signed [COEF_W-1:0]  z_coef;
  logic [ANGLE_W-1:0]        u_angle;
  logic [ANGLE_W-1:0]        v_angle;
  modport source (output valid, op, surface, mode, r_coef, z_coef, u_angle, v_angle,
                  input ready);
  modport sink (input valid, op, surface, mode, r_coef, z_coef, u_angle, v_angle,
                output ready);
endinterface

interface fsp_out_if;
  import fsp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  x_pos;
  logic signed [POS_W-1:0]  y_pos;
  logic signed [POS_W-1:0]  z_pos;
  modport source (output valid, x_pos, y_pos, z_pos, input ready);
  modport sink (input valid, x_pos, y_pos, z_pos, output ready);
endinterface

// ----- design/fsp_cordic.sv -----
module fsp_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [31:0]                   phase,
  output logic                          done,
  output logic signed [fsp_pkg::TRIG_W-1:0] cos_q,
  output logic signed [fsp_pkg::TRIG_W-1:0] sin_q
);
  import fsp_pkg::*;

  logic                     busy_r;
  logic                     done_r;
  logic [STEP_W-1:0]        step_r;
  logic [1:0]               quad_r;
  logic signed [TRIG_W-1:0] x_r, y_r, z_r;
  logic signed [TRIG_W-1:0] dx, dy, at;

  always_comb begin
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    at = $signed(TRIG_W'(atan_turn(step_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one micro-rotation per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quad_r <= phase[31:30];
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= $signed(TRIG_W'(phase[29:0]));
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  // quadrant fold
  always_comb begin
    case (quad_r)
      2'd0: begin cos_q = x_r;  sin_q = y_r;  end
      2'd1: begin cos_q = -y_r; sin_q = x_r;  end
      2'd2: begin cos_q = -x_r; sin_q = -y_r; end
      default: begin cos_q = y_r; sin_q = -x_r; end
    endcase
  end

  assign done = done_r;
endmodule

// ----- design/fsp_mulq30.sv -----
module fsp_mulq30 #(
  parameter int A_W = 44
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [A_W-1:0]             a,
  input  logic signed [fsp_pkg::TRIG_W-1:0] b,
  output logic                              done,
  output logic signed [A_W+2:0]             p
);
  import fsp_pkg::*;

  localparam int N_CH  = (A_W + 31) / 32;
  localparam int PAD_W = 32 * N_CH;
  localparam int ACC_W = PAD_W + 32;
  localparam int CNT_W = $clog2(N_CH + 1);

  logic                busy_r, rnd_r, done_r, neg_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PAD_W-1:0]    ua_r;
  logic [31:0]         ub_r;
  logic [ACC_W-1:0]    acc_r;
  logic signed [A_W+2:0] p_r;
  logic [63:0]         prod;
  logic [ACC_W-1:0]    mag;
  logic [A_W+2:0]      mag_t;

  assign prod  = ua_r[PAD_W-1 -: 32] * ub_r;
  assign mag   = (acc_r + (ACC_W'(1) << 29)) >> 30;
  assign mag_t = (A_W+3)'(mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      rnd_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(N_CH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end else if (rnd_r) begin
        done_r <= 1'b1;
      end
    end
  end

  // sign-magnitude, top 32-bit chunk first
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= a[A_W-1] ^ b[TRIG_W-1];
      ua_r  <= PAD_W'(a[A_W-1] ? A_W'(-a) : A_W'(a));
      ub_r  <= 32'(b[TRIG_W-1] ? -b : b);
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r << 32) + ACC_W'(prod);
      ua_r  <= ua_r << 32;
    end else if (rnd_r) begin
      p_r <= neg_r ? -$signed(mag_t) : $signed(mag_t);
    end
  end

  assign done = done_r;
  assign p    = p_r;
endmodule

// ----- design/fourier_surface_position_unit.sv -----
// channel  | role   | carries
// in_item  | sink   | coefficient write or evaluate request
// out_item | source | x, y, z position in q8.24
// cfg_*    | write  | ntor, mpol, field periods
//
// a write item is written to the tables as it is taken and gives no result
// an evaluate walks each mode with a start state, a run of the shared 28-step
// rotator and two passes of the chunked q30 multiplier; a final rotation and two
// multiplies then give x and y; ready is high only in idle, and a finished item
// waits in the output register, stalling the next walk at its end if not taken
// synchronous reset clears control only; the coefficient tables are not cleared
`include "fourier_surface_position_unit_defines.svh"

module fourier_surface_position_unit #(
  parameter int MAX_SURFACES = fsp_pkg::FSP_MAX_SURFACES,
  parameter int MAX_MODES    = fsp_pkg::FSP_MAX_MODES,
  parameter int ANGLE_BITS   = fsp_pkg::FSP_ANGLE_BITS,
  parameter int COEF_BITS    = fsp_pkg::FSP_COEF_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fsp_in_if.sink                          in_item,
  fsp_out_if.source                       out_item,
  input  logic                            cfg_we,
  input  logic [fsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fsp_pkg::*;

  localparam int CW     = (COEF_BITS < 32) ? COEF_BITS : 32;
  localparam int SUM_W  = CW + 3 + $clog2(MAX_MODES);
  localparam int P_W    = SUM_W + 3;
  localparam int AB     = ANGLE_BITS;
  localparam int DEPTH  = MAX_SURFACES * MAX_MODES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_MODES + 1);
  localparam logic signed [P_W-1:0] SAT_MAX = P_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [P_W-1:0] SAT_MIN = P_W'(-(64'sd1 <<< (CW - 1)));

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SET1  = 4'd1;
  localparam logic [3:0] S_SET2  = 4'd2;
  localparam logic [3:0] S_MODE  = 4'd3;
  localparam logic [3:0] S_TRIGW = 4'd4;
  localparam logic [3:0] S_MULR  = 4'd5;
  localparam logic [3:0] S_MULZ  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_FTRIG = 4'd8;
  localparam logic [3:0] S_FX    = 4'd9;
  localparam logic [3:0] S_FY    = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  function automatic logic signed [POS_W-1:0] sat_out(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] r;
    if (v > SAT_MAX) r = SAT_MAX;
    else if (v < SAT_MIN) r = SAT_MIN;
    else r = v;
    return POS_W'(r);
  endfunction

  // configuration
  logic [3:0] ntor_r;
  logic [4:0] mpol_r;
  logic [7:0] nfp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ntor_r <= 4'd0;
      mpol_r <= 5'd1;
      nfp_r  <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NTOR: ntor_r <= cfg_data[3:0];
        REG_MPOL: mpol_r <= cfg_data[4:0];
        REG_NFP:  nfp_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // control and walk state
  logic [3:0]              state_r;
  logic                    out_valid_r;
  logic [CNT_W-1:0]        k_r, cnt_r;
  logic signed [4:0]       n_r;
  logic [AB-1:0]           u_r, v_r, fpv_r, ntv_r, mu_r, phase_r;
  logic [ADDR_W-1:0]       base_r;
  logic                    surf_ok_r;
  logic signed [SUM_W-1:0] rsum_r, zsum_r;
  logic signed [POS_W-1:0] xs_r, ys_r, x_r, y_r, z_r;

  logic in_acc, wr_en, last_mode, n_wrap, out_load;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [9:0] prod_pm;
  logic [9:0] raw_cnt;
  logic [CNT_W-1:0] clamp_cnt;
  logic signed [4:0] ntor_s;

  assign in_item.ready = (state_r == S_IDLE);
  assign in_acc  = in_item.valid && in_item.ready;
  assign wr_en   = in_acc && (in_item.op == OP_WRITE)
                   && (32'(in_item.surface) < 32'(MAX_SURFACES))
                   && (32'(in_item.mode) < 32'(MAX_MODES));
  assign wr_addr = ADDR_W'(32'(in_item.surface) * 32'(MAX_MODES) + 32'(in_item.mode));
  assign rd_addr = base_r + ADDR_W'(k_r);

  // finished item moves to the output register when that is free or being taken
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_item.ready);

  // mode count: (2*ntor+1)*mpol - ntor, capped at MAX_MODES, zero for mpol 0 or a bad surface
  assign prod_pm = 10'({ntor_r, 1'b1}) * 10'(mpol_r);
  assign raw_cnt = (mpol_r == 5'd0) ? 10'd0 : prod_pm - 10'(ntor_r);
  assign clamp_cnt = !surf_ok_r ? '0
                   : (32'(raw_cnt) > 32'(MAX_MODES)) ? CNT_W'(MAX_MODES)
                   : CNT_W'(raw_cnt);
  assign ntor_s    = $signed({1'b0, ntor_r});
  assign n_wrap    = (n_r == ntor_s);
  assign last_mode = (k_r + 1'b1 == cnt_r);

  // coefficient tables, registered read
  logic [CW-1:0] r_mem [DEPTH];
  logic [CW-1:0] z_mem [DEPTH];
  logic [CW-1:0] r_rd_r, z_rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) r_mem[wr_addr] <= CW'(in_item.r_coef);
    r_rd_r <= r_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) z_mem[wr_addr] <= CW'(in_item.z_coef);
    z_rd_r <= z_mem[rd_addr];
  end

  // shared rotator and multiplier
  logic                    cor_start, cor_done;
  logic [31:0]             cor_phase;
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic                    mul_start, mul_done;
  logic signed [SUM_W-1:0] mul_a;
  logic signed [TRIG_W-1:0] mul_b;
  logic signed [P_W-1:0]   mul_p;

  assign cor_start = (state_r == S_MODE) || (state_r == S_FIN);
  assign cor_phase = (state_r == S_MODE) ? {phase_r, {(32 - AB){1'b0}}}
                                         : {v_r, {(32 - AB){1'b0}}};

  assign mul_start = cor_done
                     || (mul_done && ((state_r == S_MULR) || (state_r == S_FX)));
  always_comb begin
    case (state_r)
      S_TRIGW: mul_a = SUM_W'($signed(r_rd_r));
      S_MULR:  mul_a = SUM_W'($signed(z_rd_r));
      default: mul_a = rsum_r;
    endcase
    mul_b = ((state_r == S_TRIGW) || (state_r == S_FTRIG)) ? cos_q : sin_q;
  end

  fsp_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .phase (cor_phase),
    .done  (cor_done),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  fsp_mulq30 #(.A_W(SUM_W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_item.valid && out_item.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE:  if (in_acc && in_item.op == OP_EVAL) state_r <= S_SET1;
        S_SET1:  state_r <= S_SET2;
        S_SET2:  state_r <= (cnt_r == '0) ? S_FIN : S_MODE;
        S_MODE:  state_r <= S_TRIGW;
        S_TRIGW: if (cor_done) state_r <= S_MULR;
        S_MULR:  if (mul_done) state_r <= S_MULZ;
        S_MULZ:  if (mul_done) state_r <= last_mode ? S_FIN : S_MODE;
        S_FIN:   state_r <= S_FTRIG;
        S_FTRIG: if (cor_done) state_r <= S_FX;
        S_FX:    if (mul_done) state_r <= S_FY;
        S_FY:    if (mul_done) state_r <= S_OUT;
        S_OUT:   if (out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        u_r       <= AB'(in_item.u_angle);
        v_r       <= AB'(in_item.v_angle);
        surf_ok_r <= 32'(in_item.surface) < 32'(MAX_SURFACES);
        base_r    <= ADDR_W'(32'(in_item.surface) * 32'(MAX_MODES));
      end
      S_SET1: begin
        fpv_r <= AB'(nfp_r * v_r);
        cnt_r <= clamp_cnt;
      end
      S_SET2: begin
        ntv_r   <= AB'(ntor_r * fpv_r);
        k_r     <= '0;
        n_r     <= '0;
        mu_r    <= '0;
        phase_r <= '0;
        rsum_r  <= '0;
        zsum_r  <= '0;
      end
      S_MULR: if (mul_done) rsum_r <= rsum_r + SUM_W'(mul_p);
      S_MULZ: begin
        if (mul_done) begin
          zsum_r <= zsum_r + SUM_W'(mul_p);
          k_r    <= k_r + 1'b1;
          // n runs -ntor..ntor (from 0 at m 0), then m steps up
          if (n_wrap) begin
            n_r     <= -ntor_s;
            mu_r    <= mu_r + u_r;
            phase_r <= mu_r + u_r + ntv_r;
          end else begin
            n_r     <= n_r + 5'sd1;
            phase_r <= phase_r - fpv_r;
          end
        end
      end
      S_FX: if (mul_done) xs_r <= sat_out(mul_p);
      S_FY: if (mul_done) ys_r <= sat_out(mul_p);
      S_OUT: begin
        if (out_load) begin
          x_r <= xs_r;
          y_r <= ys_r;
          z_r <= sat_out(P_W'(zsum_r));
        end
      end
      default: ;
    endcase
  end

  assign out_item.valid = out_valid_r;
  assign out_item.x_pos = x_r;
  assign out_item.y_pos = y_r;
  assign out_item.z_pos = z_r;

  `FSP_ASSERT(a_mode_in_range, (state_r == S_MODE) |-> (k_r < cnt_r), "mode index past count")
  `FSP_ASSERT(a_n_in_range, (state_r == S_MODE) |-> ((n_r <= ntor_s) && (n_r >= -ntor_s)), "toroidal number out of range")
  `FSP_ASSERT(a_out_from_seq, $rose(out_item.valid) |-> ($past(state_r) == S_OUT), "result without finished walk")
  `FSP_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_item.valid && state_r == S_IDLE), "reset left control busy")
endmodule
